// ===== hdl/pebpt_pkg.sv =====
// Shared types and constants for the plane extent builder.
package pebpt_pkg;

    localparam int CoordW = 32;
    localparam int NormW  = 16;
    localparam int SumW   = 48;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [2:0] REG_REF_X     = 3'd0;
    localparam logic [2:0] REG_REF_Y     = 3'd1;
    localparam logic [2:0] REG_REF_Z     = 3'd2;
    localparam logic [2:0] REG_TOLERANCE = 3'd3;
    localparam logic [2:0] REG_AXIS_THR  = 3'd4;

    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    typedef struct packed {
        logic              func;
        logic [3:0]        plane_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic              last_point;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic              on_plane;
        logic signed [31:0] centroid_x;
        logic signed [31:0] centroid_y;
        logic signed [31:0] centroid_z;
        logic              normal_flipped;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_item_t;

endpackage

// ===== hdl/pebpt_if.sv =====
// Valid/ready channel interfaces for items, results and register writes.
interface pebpt_in_if;
    import pebpt_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pebpt_out_if;
    import pebpt_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pebpt_cfg_if;
    import pebpt_pkg::*;
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/plane_extent_builder_and_point_test_top.sv =====
// Top level: plane extent builder with iterative divider and point test.
//
//  channel | dir | payload
//  items   | in  | func, plane_index, point_xyz, nrm_xyz, last_point
//  results | out | result_kind, on_plane, centroid_xyz, normal_flipped
//  cfg     | in  | index (0..4), data
//
// Add item without last mark: accept, then update. Query: accept, table read,
// compare, then the transfer. Finishing add: one shared restoring divider
// takes one quotient bit a cycle (48 steps plus a load and a sign fix) for each
// axis in turn, and each axis adds one dot term; a last term, the store and
// the transfer close it.
// After reset a clearing pass zeroes every entry of the bound memory and no
// item is taken meanwhile. A stalled result holds the block until transferred.
module plane_extent_builder_and_point_test_top #(
    parameter int PLANES     = 16,
    parameter int MAX_POINTS = 65536
) (
    input  logic clk,
    input  logic rst_n,
    pebpt_in_if.sink    items,
    pebpt_out_if.source results,
    pebpt_cfg_if.sink   cfg
);
    import pebpt_pkg::*;

    localparam int PIW  = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int QW   = SumW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD, S_QREAD, S_QCMP, S_DIV, S_DIVFIX,
        S_MUL, S_ACC, S_STORE, S_OUT
    } state_t;

    state_t state_reg;
    in_item_t item_reg;
    out_item_t res_reg;
    logic [PIW-1:0] clr_reg;
    logic signed [31:0] ref_reg [3];
    logic [15:0] tol_reg;
    logic [14:0] thr_reg;
    logic signed [SumW-1:0] sum_reg [3];
    logic [CNTW-1:0] cnt_reg;
    logic signed [31:0] rb_reg [6];
    logic [191:0] bmem [PLANES];
    logic [191:0] brd_reg;
    logic [1:0] axis_reg [PLANES];
    logic [1:0] qaxis_reg;
    logic qvalid_reg;
    // divider
    logic [1:0] ax_reg;
    logic [5:0] bit_reg;
    logic [SumW-1:0] rem_reg;
    logic [SumW-1:0] quo_reg;
    logic [SumW-1:0] dvd_reg;
    logic neg_reg;
    logic signed [31:0] cen_reg [3];
    logic signed [49:0] prod_reg;
    logic signed [53:0] dot_reg;

    logic in_pidx_ok;
    logic [PIW-1:0] pidx;
    assign in_pidx_ok = (PLANES >= 16) || (item_reg.plane_index < 4'(PLANES));
    assign pidx = PIW'(item_reg.plane_index);

    assign items.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign results.valid = (state_reg == S_OUT);
    assign results.data  = res_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg[0] <= '0; ref_reg[1] <= '0; ref_reg[2] <= '0;
            tol_reg <= 16'd512;
            thr_reg <= 15'd13107;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_REF_X:     ref_reg[0] <= cfg.data.data;
                REG_REF_Y:     ref_reg[1] <= cfg.data.data;
                REG_REF_Z:     ref_reg[2] <= cfg.data.data;
                REG_TOLERANCE: tol_reg <= cfg.data.data[15:0];
                REG_AXIS_THR:  thr_reg <= cfg.data.data[14:0];
                default: ;
            endcase
        end
    end

    // bound memory: one write port, registered read
    logic mem_we;
    logic [PIW-1:0] mem_wa;
    logic [191:0] mem_wd;
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        if (state_reg == S_CLEAR)
            mem_we = 1'b1;
        else if (state_reg == S_STORE && in_pidx_ok)
        begin
            mem_we = 1'b1;
            mem_wa = pidx;
            mem_wd = {rb_reg[5], rb_reg[4], rb_reg[3], rb_reg[2], rb_reg[1], rb_reg[0]};
        end
    end
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bmem[mem_wa] <= mem_wd;
        brd_reg <= bmem[pidx];
    end

    // divider step
    logic [SumW-1:0] rem_sh;
    logic [SumW:0] trial;
    assign rem_sh = {rem_reg[SumW-2:0], dvd_reg[SumW-1]};
    assign trial  = {1'b0, rem_sh} - {{(SumW+1-CNTW){1'b0}}, cnt_reg};

    logic signed [SumW-1:0] cur_sum;
    assign cur_sum = sum_reg[ax_reg];

    logic signed [32:0] mdiff;
    logic signed [15:0] mnorm;
    always_comb
    begin
        case (ax_reg)
            2'd0: mnorm = item_reg.nrm_x;
            2'd1: mnorm = item_reg.nrm_y;
            default: mnorm = item_reg.nrm_z;
        endcase
        mdiff = 33'(cen_reg[ax_reg]) - 33'(ref_reg[ax_reg]);
    end

    function automatic logic inside_fn(logic signed [31:0] lo, logic signed [31:0] hi,
                                       logic signed [31:0] p, logic [15:0] tol);
        logic signed [33:0] l;
        logic signed [33:0] h;
        logic signed [33:0] pp;
        begin
            l = 34'(lo) - $signed({18'd0, tol});
            h = 34'(hi) + $signed({18'd0, tol});
            pp = 34'(p);
            return (l < pp) && (pp < h);
        end
    endfunction

    logic signed [31:0] bq [6];
    always_comb
        for (int i = 0; i < 6; i++)
            bq[i] = brd_reg[32*i +: 32];

    logic [15:0] ax16, ay16, az16;
    assign ax16 = item_reg.nrm_x[15] ? 16'(-item_reg.nrm_x) : item_reg.nrm_x;
    assign ay16 = item_reg.nrm_y[15] ? 16'(-item_reg.nrm_y) : item_reg.nrm_y;
    assign az16 = item_reg.nrm_z[15] ? 16'(-item_reg.nrm_z) : item_reg.nrm_z;

    logic [1:0] new_axis;
    always_comb
    begin
        if (ax16 > {1'b0, thr_reg})      new_axis = AXIS_X;
        else if (ay16 > {1'b0, thr_reg}) new_axis = AXIS_Y;
        else if (az16 > {1'b0, thr_reg}) new_axis = AXIS_Z;
        else                             new_axis = AXIS_NONE;
    end

    logic signed [31:0] pt [3];
    assign pt[0] = item_reg.point_x;
    assign pt[1] = item_reg.point_y;
    assign pt[2] = item_reg.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
            sum_reg[0] <= '0; sum_reg[1] <= '0; sum_reg[2] <= '0;
            qvalid_reg <= 1'b0;
            for (int i = 0; i < PLANES; i++)
                axis_reg[i] <= AXIS_NONE;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PIW'(PLANES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (items.valid)
                    begin
                        item_reg <= items.data;
                        state_reg <= (items.data.func == FUNC_QUERY) ? S_QREAD : S_ADD;
                    end
                S_ADD:
                begin
                    if (cnt_reg < CNTW'(MAX_POINTS))
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            sum_reg[a] <= sum_reg[a] + SumW'(pt[a]);
                            if (cnt_reg == '0 || pt[a] < rb_reg[2*a])
                                rb_reg[2*a] <= pt[a];
                            if (cnt_reg == '0 || pt[a] > rb_reg[2*a+1])
                                rb_reg[2*a+1] <= pt[a];
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (item_reg.last_point)
                    begin
                        ax_reg <= 2'd0;
                        state_reg <= S_DIVFIX;
                        dot_reg <= '0;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_DIVFIX:
                begin
                    // load magnitude of the current axis sum
                    neg_reg <= cur_sum[SumW-1];
                    dvd_reg <= cur_sum[SumW-1] ? SumW'(-cur_sum) : cur_sum;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    bit_reg <= 6'(SumW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dvd_reg <= dvd_reg << 1;
                    if (!trial[SumW])
                    begin
                        rem_reg <= trial[SumW-1:0];
                        quo_reg <= {quo_reg[SumW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[SumW-2:0], 1'b0};
                    end
                    if (bit_reg == '0)
                        state_reg <= S_MUL;
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                S_MUL:
                begin
                    if (cnt_reg == '0)
                        cen_reg[ax_reg] <= '0;
                    else
                        cen_reg[ax_reg] <= neg_reg ? 32'(-quo_reg) : quo_reg[31:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    prod_reg <= 50'(mdiff) * 50'(mnorm);
                    if (ax_reg != 2'd0)
                        dot_reg <= dot_reg + 54'(prod_reg);
                    if (ax_reg == 2'd3)
                        state_reg <= S_STORE;
                    else
                    begin
                        ax_reg <= ax_reg + 1'b1;
                        state_reg <= (ax_reg == 2'd2) ? S_ACC : S_DIVFIX;
                    end
                end
                S_STORE:
                begin
                    if (in_pidx_ok)
                        axis_reg[pidx] <= new_axis;
                    res_reg.result_kind <= KIND_REPORT;
                    res_reg.on_plane <= 1'b0;
                    res_reg.centroid_x <= cen_reg[0];
                    res_reg.centroid_y <= cen_reg[1];
                    res_reg.centroid_z <= cen_reg[2];
                    res_reg.normal_flipped <= dot_reg[53];
                    sum_reg[0] <= '0; sum_reg[1] <= '0; sum_reg[2] <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_QREAD:
                begin
                    qaxis_reg <= axis_reg[pidx];
                    qvalid_reg <= in_pidx_ok;
                    state_reg <= S_QCMP;
                end
                S_QCMP:
                begin
                    res_reg.result_kind <= KIND_QUERY;
                    res_reg.centroid_x <= '0;
                    res_reg.centroid_y <= '0;
                    res_reg.centroid_z <= '0;
                    res_reg.normal_flipped <= 1'b0;
                    case (qaxis_reg)
                        AXIS_X: res_reg.on_plane <= qvalid_reg
                            && inside_fn(bq[2], bq[3], pt[1], tol_reg)
                            && inside_fn(bq[4], bq[5], pt[2], tol_reg);
                        AXIS_Y: res_reg.on_plane <= qvalid_reg
                            && inside_fn(bq[0], bq[1], pt[0], tol_reg)
                            && inside_fn(bq[4], bq[5], pt[2], tol_reg);
                        AXIS_Z: res_reg.on_plane <= qvalid_reg
                            && inside_fn(bq[0], bq[1], pt[0], tol_reg)
                            && inside_fn(bq[2], bq[3], pt[1], tol_reg);
                        default: res_reg.on_plane <= 1'b0;
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (results.ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !items.ready)
        else $error("item taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |=> ($stable(results.data) && results.valid))
        else $error("result changed while stalled");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_POINTS))
        else $error("point count overflow");
    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.data.result_kind == KIND_REPORT) |-> !results.data.on_plane)
        else $error("report carries on_plane");

endmodule

// ===== test/pebpt_test_if.sv =====
// Testbench constants used by the plane extent builder testbench.
`timescale 1ns / 1ps
package pebpt_test_pkg;
    localparam int IdlePct = 34;
endpackage

// ===== test/plane_extent_builder_and_point_test_top_test.sv =====
// Testbench for the plane extent builder: predicted bounds, centroids and point tests.
`timescale 1ns / 1ps
module plane_extent_builder_and_point_test_top_test;
    import pebpt_pkg::*;
    import pebpt_test_pkg::*;

    localparam int NPlanes = 16;
    localparam int MaxPts  = 65536;
    localparam int StallLimit = 20000;

    logic clk;
    logic rst_n;
    pebpt_in_if  items ();
    pebpt_out_if results ();
    pebpt_cfg_if cfg ();

    plane_extent_builder_and_point_test_top dut (
        .clk(clk), .rst_n(rst_n), .items(items), .results(results), .cfg(cfg)
    );

    // predictor state
    logic signed [31:0] ref_pt [3];
    logic [15:0] tol_reg;
    logic [14:0] thr_reg;
    logic signed [47:0] acc [3];
    logic [16:0] pts;
    logic signed [31:0] run_b [6];
    logic signed [31:0] tab_b [NPlanes][6];
    logic [1:0] tab_axis [NPlanes];

    out_item_t expected_q[$];
    int errors = 0;
    int stall_cnt = 0;
    bit quiet;      // no idling stretch
    logic signed [31:0] built_lo [3];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < IdlePct);
    endfunction

    function automatic logic signed [31:0] mean_trunc(logic signed [47:0] s, logic [16:0] n);
        longint q;
        longint sv;
        sv = longint'(s);
        if (n == 0) return '0;
        if (sv < 0) q = -((-sv) / longint'(n));
        else q = sv / longint'(n);
        return q[31:0];
    endfunction

    function automatic bit strictly_in(logic signed [31:0] lo, logic signed [31:0] hi,
                                       logic signed [31:0] p);
        longint l, h, t;
        l = longint'(lo); h = longint'(hi); t = longint'(tol_reg);
        return (l - t < longint'(p)) && (longint'(p) < h + t);
    endfunction

    function automatic int absv(logic signed [15:0] v);
        int x;
        x = int'(v);
        return x < 0 ? -x : x;
    endfunction

    task automatic predict_item(in_item_t it);
        out_item_t r;
        logic signed [31:0] c [3];
        logic signed [31:0] pv [3];
        logic signed [15:0] nv [3];
        longint dot;
        logic [1:0] ax;
        int a;
        r = '0;
        pv[0] = it.point_x; pv[1] = it.point_y; pv[2] = it.point_z;
        nv[0] = it.nrm_x; nv[1] = it.nrm_y; nv[2] = it.nrm_z;
        if (it.func == FUNC_QUERY)
        begin
            r.result_kind = KIND_QUERY;
            ax = tab_axis[it.plane_index];
            case (ax)
                AXIS_X: r.on_plane = strictly_in(tab_b[it.plane_index][2], tab_b[it.plane_index][3], pv[1])
                                  && strictly_in(tab_b[it.plane_index][4], tab_b[it.plane_index][5], pv[2]);
                AXIS_Y: r.on_plane = strictly_in(tab_b[it.plane_index][0], tab_b[it.plane_index][1], pv[0])
                                  && strictly_in(tab_b[it.plane_index][4], tab_b[it.plane_index][5], pv[2]);
                AXIS_Z: r.on_plane = strictly_in(tab_b[it.plane_index][0], tab_b[it.plane_index][1], pv[0])
                                  && strictly_in(tab_b[it.plane_index][2], tab_b[it.plane_index][3], pv[1]);
                default: r.on_plane = 1'b0;
            endcase
            expected_q = {expected_q, r};
            return;
        end
        if (pts < MaxPts)
        begin
            for (a = 0; a < 3; a++)
            begin
                acc[a] = acc[a] + 48'(pv[a]);
                if (pts == 0 || pv[a] < run_b[2*a]) run_b[2*a] = pv[a];
                if (pts == 0 || pv[a] > run_b[2*a+1]) run_b[2*a+1] = pv[a];
            end
            pts = pts + 17'd1;
        end
        if (!it.last_point) return;
        dot = 0;
        for (a = 0; a < 3; a++)
        begin
            c[a] = mean_trunc(acc[a], pts);
            dot += (longint'(c[a]) - longint'(ref_pt[a])) * longint'(nv[a]);
        end
        if (absv(nv[0]) > int'(thr_reg)) ax = AXIS_X;
        else if (absv(nv[1]) > int'(thr_reg)) ax = AXIS_Y;
        else if (absv(nv[2]) > int'(thr_reg)) ax = AXIS_Z;
        else ax = AXIS_NONE;
        for (a = 0; a < 6; a++) tab_b[it.plane_index][a] = run_b[a];
        tab_axis[it.plane_index] = ax;
        r.result_kind = KIND_REPORT;
        r.centroid_x = c[0]; r.centroid_y = c[1]; r.centroid_z = c[2];
        r.normal_flipped = dot < 0;
        expected_q = {expected_q, r};
        for (a = 0; a < 3; a++) acc[a] = '0;
        pts = '0;
    endtask

    task automatic send_item(in_item_t it);
        while (idle_now()) @(posedge clk);
        items.data  <= it;
        items.valid <= 1'b1;
        do @(posedge clk); while (!items.ready);
        predict_item(it);
        // drop valid after the transfer; the block is busy then anyway
        items.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg.data  <= '{index: idx, data: val};
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_REF_X: ref_pt[0] = val;
            REG_REF_Y: ref_pt[1] = val;
            REG_REF_Z: ref_pt[2] = val;
            REG_TOLERANCE: tol_reg = val[15:0];
            REG_AXIS_THR: thr_reg = val[14:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        it.func = 1'($urandom_range(1));
        it.plane_index = 4'($urandom_range(15));
        it.point_x = $urandom; it.point_y = $urandom; it.point_z = $urandom;
        it.nrm_x = 16'($urandom_range(32768) - 16384);
        it.nrm_y = 16'($urandom_range(32768) - 16384);
        it.nrm_z = 16'($urandom_range(32768) - 16384);
        it.last_point = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic logic signed [31:0] near_coord(int k);
        logic signed [31:0] v;
        if ($urandom_range(9) == 0) v = $urandom;
        else v = built_lo[k] + $signed($urandom_range(8000)) - 2000;
        return v;
    endfunction

    task automatic build_plane(logic [3:0] idx, int n, bit wide);
        in_item_t it;
        int i, dom;
        dom = $urandom_range(2);
        for (i = 0; i < 3; i++) built_lo[i] = wide ? $urandom : $signed($urandom_range(40000)) - 20000;
        for (i = 0; i < n; i++)
        begin
            it = '0;
            it.func = FUNC_ADD;
            it.plane_index = idx;
            it.point_x = wide ? $urandom : built_lo[0] + $urandom_range(4000);
            it.point_y = wide ? $urandom : built_lo[1] + $urandom_range(4000);
            it.point_z = wide ? $urandom : built_lo[2] + $urandom_range(4000);
            it.nrm_x = 16'($urandom_range(32768) - 16384);
            it.nrm_y = 16'($urandom_range(32768) - 16384);
            it.nrm_z = 16'($urandom_range(32768) - 16384);
            if (dom == 0) it.nrm_x = $urandom_range(1) ? 16'sd16000 : -16'sd16000;
            if (dom == 1) it.nrm_y = $urandom_range(1) ? 16'sd16000 : -16'sd16000;
            if (dom == 2) it.nrm_z = $urandom_range(1) ? 16'sd16000 : -16'sd16000;
            it.last_point = (i == n - 1);
            send_item(it);
        end
    endtask

    task automatic query_near(logic [3:0] idx);
        in_item_t it;
        it = rand_item();
        it.func = FUNC_QUERY;
        it.plane_index = idx;
        it.point_x = near_coord(0);
        it.point_y = near_coord(1);
        it.point_z = near_coord(2);
        send_item(it);
    endtask

    task automatic test_directed();
        in_item_t it;
        int i;
        // query of planes never built
        it = '0; it.func = FUNC_QUERY; it.plane_index = 4'd15; send_item(it);
        // single point plane at extremes
        it = '0; it.func = FUNC_ADD; it.plane_index = 4'd0;
        it.point_x = 32'h8000_0000; it.point_y = 32'h7fff_ffff; it.point_z = -1;
        it.nrm_x = -16'sd16384; it.nrm_y = 16'sd16384; it.nrm_z = 16'sd0;
        it.last_point = 1'b1;
        send_item(it);
        // two extreme points: negative sum truncation
        it.plane_index = 4'd1; it.last_point = 1'b0; it.point_x = 32'h8000_0000;
        it.point_y = 32'h8000_0000; it.point_z = 32'h8000_0000; send_item(it);
        it.last_point = 1'b1; it.point_x = 32'h7fff_ffff; it.point_y = 3;
        it.point_z = 32'h8000_0000; it.nrm_x = 16'sd0; it.nrm_y = 16'sd0;
        it.nrm_z = 16'sd16384;
        send_item(it);
        // axis none: all normals at threshold
        it = '0; it.plane_index = 4'd2; it.nrm_x = 16'sd13107; it.nrm_y = -16'sd13107;
        it.nrm_z = 16'sd13107; it.last_point = 1'b1; send_item(it);
        // boundary queries on plane 1 (axis z) and plane 0 (axis x)
        for (i = 0; i < 6; i++)
        begin
            it = '0; it.func = FUNC_QUERY; it.plane_index = 4'(i[0]);
            it.point_x = (i < 2) ? 32'h8000_0000 : (i < 4 ? 32'h7fff_ffff : -513);
            it.point_y = (i < 3) ? 3 + 511 : -1;
            it.point_z = (i < 3) ? -512 : 32'h8000_0000 + 511;
            it.last_point = 1'b1; it.nrm_x = 16'sd16384;
            send_item(it);
        end
        it = '0; it.func = FUNC_QUERY; it.plane_index = 4'd2; send_item(it);
        drain();
    endtask

    task automatic test_config_sweep();
        int s, p;
        logic [31:0] vals [4] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234};
        for (s = 0; s < 4; s++)
        begin
            write_reg(REG_REF_X, $urandom_range(1) ? vals[s] : $urandom);
            write_reg(REG_REF_Y, vals[(s + 1) % 4]);
            write_reg(REG_REF_Z, vals[(s + 2) % 4]);
            write_reg(REG_TOLERANCE, s == 0 ? 0 : (s == 1 ? 65535 : $urandom_range(65535)));
            write_reg(REG_AXIS_THR, s == 0 ? 0 : (s == 1 ? 16384 : $urandom_range(16384)));
            for (p = 0; p < 12; p++)
            begin
                build_plane(4'($urandom_range(15)), $urandom_range(1, 5),
                            $urandom_range(3) == 0);
                repeat (3) query_near(4'($urandom_range(15)));
            end
            drain();
        end
        write_reg(REG_TOLERANCE, 512);
        write_reg(REG_AXIS_THR, 13107);
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < 300; i++) send_item(rand_item());
        drain();
    endtask

    task automatic test_no_idle();
        int p;
        quiet = 1'b1;
        for (p = 0; p < 10; p++)
        begin
            build_plane(p[3:0], 4, 1'b0);
            query_near(p[3:0]);
        end
        drain();
        quiet = 1'b0;
    endtask

    // result checker and sink idling
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, results.data);
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (results.data.result_kind !== exp_r.result_kind ||
                        results.data.on_plane !== exp_r.on_plane ||
                        results.data.centroid_x !== exp_r.centroid_x ||
                        results.data.centroid_y !== exp_r.centroid_y ||
                        results.data.centroid_z !== exp_r.centroid_z ||
                        results.data.normal_flipped !== exp_r.normal_flipped)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_r, results.data);
                        errors++;
                    end
                end
            end
            results.ready <= !idle_now();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready) ||
            (cfg.valid && cfg.ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == StallLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int a, p;
        quiet = 1'b0;
        items.valid = 1'b0; items.data = '0;
        cfg.valid = 1'b0; cfg.data = '0;
        ref_pt[0] = '0; ref_pt[1] = '0; ref_pt[2] = '0;
        tol_reg = 16'd512; thr_reg = 15'd13107; pts = '0;
        for (a = 0; a < 3; a++) acc[a] = '0;
        for (a = 0; a < 6; a++) run_b[a] = '0;
        for (p = 0; p < NPlanes; p++)
        begin
            tab_axis[p] = AXIS_NONE;
            for (a = 0; a < 6; a++) tab_b[p][a] = '0;
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random_mix();
        test_no_idle();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
